>>> rtl/altimeter_frame_receiver_crc16_defines.svh
// Assertion macros shared by the receiver RTL files.
// Expects clk and rst_n in the scope where a macro is used.
`ifndef ALTIMETER_FRAME_RECEIVER_CRC16_DEFINES_SVH
`define ALTIMETER_FRAME_RECEIVER_CRC16_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define AFRC16_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define AFRC16_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/afrc16_pkg.sv
// Types and constants for the framed CRC-16/X.25 receiver.
// No dependencies; imported by every RTL module of the block.
`default_nettype none

package afrc16_pkg;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_HEADER_FIRST  = 2'd0;
    localparam cfg_index_t CFG_HEADER_SECOND = 2'd1;
    localparam cfg_index_t CFG_VERSION       = 2'd2;

    localparam logic [15:0] CRC_INIT    = 16'hFFFF;
    localparam logic [15:0] CRC_POLY    = 16'h8408;
    localparam logic [15:0] CRC_XOR_OUT = 16'hFFFF;
    localparam logic [15:0] CRC_LSB     = 16'h0001;

    typedef logic [3:0] byte_pos_t;
    localparam byte_pos_t POS_AFTER_START = 4'd3;
    localparam byte_pos_t POS_DIST_HI     = 4'd4;
    localparam byte_pos_t POS_DIST_LO     = 4'd5;
    localparam byte_pos_t POS_SIG_HI      = 4'd10;
    localparam byte_pos_t POS_SIG_LO      = 4'd11;
    localparam byte_pos_t POS_STAT_HI     = 4'd12;
    localparam byte_pos_t POS_STAT_LO     = 4'd13;
    localparam byte_pos_t POS_CRC_LO      = 4'd14;
    localparam byte_pos_t POS_CRC_HI      = 4'd15;

    typedef logic [1:0] win_fill_t;
    localparam win_fill_t WIN_FULL = 2'd2;

    typedef struct packed {
        logic [7:0] header_first;
        logic [7:0] header_second;
        logic [7:0] version;
    } frame_cfg_t;

    typedef struct packed {
        logic        frame_ok;
        logic [15:0] distance;
        logic [15:0] signal_strength;
        logic [15:0] status_word;
    } frame_result_t;

endpackage

`default_nettype wire

>>> rtl/altimeter_frame_receiver_crc16.sv
// Framed serial receiver: takes one byte per word, hunts for the configured
// three-byte start, checks the CRC-16/X.25 over bytes 0..13 of a 16-byte frame
// against bytes 14/15 and emits one result word per frame. Every byte goes
// through an input register and is then handled by the parser, which
// carries the hunt window, frame position, running CRC and the captured
// words; a result lands in an output register. Throughput is one byte per
// clock; a byte waits in the input register only while the output register
// holds an untaken result and the byte closes a frame. The last frame byte
// passes the input register, and its result the output register, before
// out_valid rises. Depends on afrc16_pkg, afrc16_parser, afrc16_crc_step and
// the assertion macro header.
`default_nettype none
`include "altimeter_frame_receiver_crc16_defines.svh"

module altimeter_frame_receiver_crc16
(
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_wr_en,
    input  wire afrc16_pkg::cfg_index_t      cfg_index,
    input  wire logic [7:0]                  cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [7:0]                  rx_byte,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic                             frame_ok,
    output logic [15:0]                      distance,
    output logic [15:0]                      signal_strength,
    output logic [15:0]                      status_word
);
    import afrc16_pkg::*;

    frame_cfg_t    cfg_reg;
    logic          in_valid_reg;
    logic [7:0]    in_byte_reg;
    logic          out_valid_reg, out_valid_next;
    frame_result_t out_result_reg;
    frame_result_t result;
    logic          emit;
    logic          slot_free;
    logic          proc_go;
    logic          res_load;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_HEADER_FIRST:  cfg_reg.header_first  <= cfg_data;
                CFG_HEADER_SECOND: cfg_reg.header_second <= cfg_data;
                CFG_VERSION:       cfg_reg.version       <= cfg_data;
                default:           ;
            endcase
        end
    end

    afrc16_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .step    (proc_go),
        .byte_in (in_byte_reg),
        .emit    (emit),
        .result  (result)
    );

    // hold the byte only when it closes a frame and the result slot is busy
    assign slot_free = !out_valid_reg || out_ready;
    assign proc_go   = in_valid_reg && (!emit || slot_free);
    assign res_load  = proc_go && emit;
    assign in_ready  = !in_valid_reg || proc_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (in_ready)
            in_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
            in_byte_reg <= rx_byte;
    end

    always_comb
    begin
        if (res_load)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
            out_result_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign frame_ok        = out_result_reg.frame_ok;
    assign distance        = out_result_reg.distance;
    assign signal_strength = out_result_reg.signal_strength;
    assign status_word     = out_result_reg.status_word;

    `AFRC16_ASSERT_NEXT(a_result_shown, res_load, out_valid_reg,
        "loaded result not presented")
    `AFRC16_ASSERT_NEXT(a_byte_held, in_valid_reg && !proc_go,
        in_valid_reg && $stable(in_byte_reg), "stalled byte lost from input register")
    `AFRC16_ASSERT_SAME(a_no_overwrite, res_load, !out_valid_reg || out_ready,
        "result overwrites an untaken word")

endmodule

`default_nettype wire

>>> rtl/afrc16_crc_step.sv
// One-byte update of the reflected CRC-16 (poly 0x8408).
// Depends on afrc16_pkg for the polynomial.
`default_nettype none

module afrc16_crc_step
(
    input  wire logic [15:0] crc_in,
    input  wire logic [7:0]  data,
    output logic      [15:0] crc_out
);
    import afrc16_pkg::*;

    logic [15:0] c;

    // eight bit steps, LSB first
    always_comb
    begin
        c = crc_in ^ {8'h00, data};
        for (int k = 0; k < 8; k++)
        begin
            if ((c & CRC_LSB) != 16'h0000)
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        crc_out = c;
    end

endmodule

`default_nettype wire

>>> rtl/afrc16_parser.sv
// Frame hunt, position tracking, CRC accumulation and word capture.
// Depends on afrc16_pkg, afrc16_crc_step and the assertion macro header.
`default_nettype none
`include "altimeter_frame_receiver_crc16_defines.svh"

module afrc16_parser
(
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire afrc16_pkg::frame_cfg_t     cfg,
    input  wire logic                       step,
    input  wire logic [7:0]                 byte_in,
    output logic                            emit,
    output afrc16_pkg::frame_result_t       result
);
    import afrc16_pkg::*;

    logic [15:0] hunt_window_reg, hunt_window_next;
    win_fill_t   window_fill_reg, window_fill_next;
    logic        in_frame_reg, in_frame_next;
    byte_pos_t   byte_pos_reg, byte_pos_next;
    logic [15:0] crc_reg, crc_next;
    logic [15:0] dist_reg, dist_next;
    logic [15:0] sig_reg, sig_next;
    logic [15:0] stat_reg, stat_next;
    logic [7:0]  crc_low_reg, crc_low_next;
    logic [15:0] held_dist_reg, held_dist_next;
    logic [15:0] held_sig_reg, held_sig_next;
    logic [15:0] held_stat_reg, held_stat_next;

    logic [15:0] crc_h1, crc_h2, crc_start, crc_run;
    logic        start_hit;
    logic        crc_match;

    // CRC over the three start bytes; on a hit they equal the configured bytes
    afrc16_crc_step u_crc_h1 (.crc_in(CRC_INIT), .data(cfg.header_first),  .crc_out(crc_h1));
    afrc16_crc_step u_crc_h2 (.crc_in(crc_h1),   .data(cfg.header_second), .crc_out(crc_h2));
    afrc16_crc_step u_crc_h3 (.crc_in(crc_h2),   .data(cfg.version),       .crc_out(crc_start));
    afrc16_crc_step u_crc_run (.crc_in(crc_reg), .data(byte_in),           .crc_out(crc_run));

    assign start_hit = (window_fill_reg == WIN_FULL)
                    && (hunt_window_reg[15:8] == cfg.header_first)
                    && (hunt_window_reg[7:0] == cfg.header_second)
                    && (byte_in == cfg.version);

    assign emit      = in_frame_reg && (byte_pos_reg == POS_CRC_HI);
    assign crc_match = ({byte_in, crc_low_reg} == (crc_reg ^ CRC_XOR_OUT));

    always_comb
    begin
        result.frame_ok        = crc_match;
        result.distance        = crc_match ? dist_reg : held_dist_reg;
        result.signal_strength = crc_match ? sig_reg  : held_sig_reg;
        result.status_word     = crc_match ? stat_reg : held_stat_reg;
    end

    always_comb
    begin
        hunt_window_next = hunt_window_reg;
        window_fill_next = window_fill_reg;
        in_frame_next    = in_frame_reg;
        byte_pos_next    = byte_pos_reg;
        crc_next         = crc_reg;
        dist_next        = dist_reg;
        sig_next         = sig_reg;
        stat_next        = stat_reg;
        crc_low_next     = crc_low_reg;
        held_dist_next   = held_dist_reg;
        held_sig_next    = held_sig_reg;
        held_stat_next   = held_stat_reg;

        if (step)
        begin
            if (!in_frame_reg)
            begin
                if (start_hit)
                begin
                    crc_next         = crc_start;
                    in_frame_next    = 1'b1;
                    byte_pos_next    = POS_AFTER_START;
                    hunt_window_next = 16'h0000;
                    window_fill_next = '0;
                    dist_next        = 16'h0000;
                    sig_next         = 16'h0000;
                    stat_next        = 16'h0000;
                end
                else
                begin
                    hunt_window_next = {hunt_window_reg[7:0], byte_in};
                    if (window_fill_reg != WIN_FULL)
                        window_fill_next = window_fill_reg + 2'd1;
                end
            end
            else
            begin
                if (byte_pos_reg < POS_CRC_LO)
                    crc_next = crc_run;

                case (byte_pos_reg)
                    POS_DIST_HI: dist_next = {byte_in, 8'h00};
                    POS_DIST_LO: dist_next = {dist_reg[15:8], byte_in};
                    POS_SIG_HI:  sig_next  = {byte_in, 8'h00};
                    POS_SIG_LO:  sig_next  = {sig_reg[15:8], byte_in};
                    POS_STAT_HI: stat_next = {byte_in, 8'h00};
                    POS_STAT_LO: stat_next = {stat_reg[15:8], byte_in};
                    POS_CRC_LO:  crc_low_next = byte_in;
                    default:     ;
                endcase

                if (byte_pos_reg == POS_CRC_HI)
                begin
                    // close the frame and go back to hunting with an empty window
                    if (crc_match)
                    begin
                        held_dist_next = dist_reg;
                        held_sig_next  = sig_reg;
                        held_stat_next = stat_reg;
                    end
                    in_frame_next    = 1'b0;
                    byte_pos_next    = '0;
                    crc_next         = CRC_INIT;
                    hunt_window_next = 16'h0000;
                    window_fill_next = '0;
                end
                else
                begin
                    byte_pos_next = byte_pos_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hunt_window_reg <= 16'h0000;
            window_fill_reg <= '0;
            in_frame_reg    <= 1'b0;
            byte_pos_reg    <= '0;
            crc_reg         <= CRC_INIT;
            crc_low_reg     <= 8'h00;
            held_dist_reg   <= 16'h0000;
            held_sig_reg    <= 16'h0000;
            held_stat_reg   <= 16'h0000;
        end
        else
        begin
            hunt_window_reg <= hunt_window_next;
            window_fill_reg <= window_fill_next;
            in_frame_reg    <= in_frame_next;
            byte_pos_reg    <= byte_pos_next;
            crc_reg         <= crc_next;
            crc_low_reg     <= crc_low_next;
            held_dist_reg   <= held_dist_next;
            held_sig_reg    <= held_sig_next;
            held_stat_reg   <= held_stat_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dist_reg <= dist_next;
        sig_reg  <= sig_next;
        stat_reg <= stat_next;
    end

    `AFRC16_ASSERT_SAME(a_pos_in_frame, in_frame_reg, byte_pos_reg >= POS_AFTER_START,
        "frame position below first data byte")
    `AFRC16_ASSERT_SAME(a_pos_hunting, !in_frame_reg, byte_pos_reg == '0,
        "position not cleared while hunting")
    `AFRC16_ASSERT_NEXT(a_frame_close, step && emit,
        !in_frame_reg && (window_fill_reg == '0) && (crc_reg == CRC_INIT),
        "frame end did not return to hunting")

endmodule

`default_nettype wire
